// File: rtl/utu_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utu_pkg;

    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int POINT_W  = 21;
    localparam int DUE_W    = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [UNIT_W-1:0]  REPL_UNIT    = 16'hFFFD;
    localparam logic [UNIT_W-1:0]  HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0]  LO_SURR_BASE = 16'hDC00;
    localparam logic [POINT_W-1:0] SUPP_BASE    = 21'h10000;
    localparam logic [POINT_W-1:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [POINT_W-1:0] MIN_3BYTE    = 21'h800;
    localparam logic [POINT_W-1:0] SURR_LO      = 21'hD800;
    localparam logic [POINT_W-1:0] SURR_HI      = 21'hDFFF;

    // one result item
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_of_run;
        logic              string_end;
    } t_unit;

    // results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] num;
        t_unit      first;
        t_unit      second;
    } t_dec_out;

endpackage

// File: rtl/utu_decode.sv
// Per-byte UTF-8 decoder: sequence state registers and the result logic.
module utu_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [utu_pkg::BYTE_W-1:0]  i_byte,
    output utu_pkg::t_dec_out           o_dec
);
    import utu_pkg::*;

    logic [POINT_W-1:0] r_partial, n_partial;
    logic [DUE_W-1:0]   r_due,     n_due;
    logic [DUE_W-1:0]   r_len,     n_len;

    logic [POINT_W-1:0] shifted;
    logic [POINT_W-1:0] cp;
    logic [POINT_W-1:0] offs;
    logic [DUE_W-1:0]   due_dec;
    logic               bad_point;

    assign shifted = {r_partial[POINT_W-7:0], i_byte[5:0]};
    assign due_dec = r_due - DUE_W'(1);

    // len counts continuation bytes: 2 means a 3-byte form, 3 a 4-byte form
    assign bad_point = ((r_len == DUE_W'(2)) && (shifted < MIN_3BYTE))
                    || ((r_len == DUE_W'(3)) && (shifted < SUPP_BASE))
                    || ((shifted >= SURR_LO) && (shifted <= SURR_HI))
                    || (shifted > MAX_POINT);
    assign cp   = bad_point ? {{(POINT_W-UNIT_W){1'b0}}, REPL_UNIT} : shifted;
    assign offs = cp - SUPP_BASE;

    always_comb begin
        n_partial = r_partial;
        n_due     = r_due;
        n_len     = r_len;
        o_dec     = '0;

        if (i_byte == '0) begin
            if (r_due != '0) begin
                o_dec.num    = 2'd2;
                o_dec.first  = '{REPL_UNIT, 1'b0, 1'b0};
                o_dec.second = '{'0, 1'b1, 1'b1};
            end else begin
                o_dec.num   = 2'd1;
                o_dec.first = '{'0, 1'b1, 1'b1};
            end
            n_partial = '0;
            n_due     = '0;
            n_len     = '0;
        end else if (r_due != '0) begin
            if (i_byte[7:6] != 2'b10) begin
                // broken sequence: the offending byte is swallowed
                o_dec.num   = 2'd1;
                o_dec.first = '{REPL_UNIT, 1'b1, 1'b0};
                n_partial   = '0;
                n_due       = '0;
                n_len       = '0;
            end else if (due_dec != '0) begin
                n_partial = shifted;
                n_due     = due_dec;
            end else begin
                if (cp < SUPP_BASE) begin
                    o_dec.num   = 2'd1;
                    o_dec.first = '{cp[UNIT_W-1:0], 1'b1, 1'b0};
                end else begin
                    o_dec.num    = 2'd2;
                    o_dec.first  = '{HI_SURR_BASE | {6'b0, offs[19:10]}, 1'b0, 1'b0};
                    o_dec.second = '{LO_SURR_BASE | {6'b0, offs[9:0]}, 1'b1, 1'b0};
                end
                n_partial = '0;
                n_due     = '0;
                n_len     = '0;
            end
        end else if (i_byte[7] == 1'b0) begin
            o_dec.num   = 2'd1;
            o_dec.first = '{{8'h00, i_byte}, 1'b1, 1'b0};
        end else if (i_byte inside {[8'hC2:8'hDF]}) begin
            n_partial = {16'b0, i_byte[4:0]};
            n_due     = DUE_W'(1);
            n_len     = DUE_W'(1);
        end else if (i_byte[7:4] == 4'hE) begin
            n_partial = {17'b0, i_byte[3:0]};
            n_due     = DUE_W'(2);
            n_len     = DUE_W'(2);
        end else if (i_byte[7:3] == 5'b11110) begin
            n_partial = {18'b0, i_byte[2:0]};
            n_due     = DUE_W'(3);
            n_len     = DUE_W'(3);
        end else begin
            o_dec.num   = 2'd1;
            o_dec.first = '{REPL_UNIT, 1'b1, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_due     <= '0;
            r_len     <= '0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_due     <= n_due;
            r_len     <= n_len;
        end
    end

endmodule

// File: rtl/utu_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module utu_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utu_pkg::t_dec_out i_dec,
    output logic              o_room,
    output logic              o_valid,
    output utu_pkg::t_unit    o_unit,
    input  logic              i_pop
);
    import utu_pkg::*;

    t_unit            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [1:0]       push_num;
    logic             pop_ok;

    assign push_num = i_push ? i_dec.num : 2'd0;
    assign o_valid  = (r_count != '0);
    assign pop_ok   = o_valid && i_pop;
    assign o_unit   = r_mem[r_rd_ptr];
    // room for the worst case of two results from the next byte
    assign o_room   = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push_num);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop_ok);
        n_count  = r_count + CNT_W'(push_num) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_dec.first;
        end
        if (push_num == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_dec.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level.
// A byte's results are decoded combinationally and registered into the queue on its transfer.
// Throughput: one byte per cycle while the queue has room; a byte giving two units
// (surrogate pair or flush before the terminator) is buffered in a 4-entry queue.
// Reset: synchronous, active low; clears the sequence state and empties the queue.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] code_unit
    output logic        o_m_tlast,   // last_of_run
    output logic        o_m_tuser    // [0] string_end
);
    import utu_pkg::*;

    t_dec_out dec;
    t_unit    head;
    logic     room;
    logic     in_xfer;

    assign o_s_tready = room;
    assign in_xfer    = i_s_tvalid && room;

    utu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_byte   (i_s_tdata),
        .o_dec    (dec)
    );

    utu_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_dec   (dec),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .o_unit  (head),
        .i_pop   (i_m_tready)
    );

    assign o_m_tdata = head.code_unit;
    assign o_m_tlast = head.last_of_run;
    assign o_m_tuser = head.string_end;

    a_end_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 16'h0000 && o_m_tlast))
        else $error("string end unit not zero or not last");

    a_hi_surr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[15:10] == 6'b110110) |-> !o_m_tlast)
        else $error("high surrogate marked last");

    a_lo_surr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[15:10] == 6'b110111) |-> o_m_tlast)
        else $error("low surrogate not marked last");

    a_zero_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata == 8'h00) |=> o_m_tvalid)
        else $error("terminator produced no result");

endmodule
